FILE: rtl/tbcenc_pkg.sv
// ----------------------------------------------------------------------------
// tbcenc_pkg
// Shared types and constants of the text field to binary copy encoder.
// ----------------------------------------------------------------------------
package tbcenc_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned TYPE_W  = 2;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned NB_W    = 4;
   localparam int unsigned KIND_W  = 2;

   localparam logic [KIND_W-1:0] KIND_NULL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VALUE = 2'd2;

   localparam logic [TYPE_W-1:0] TYPE_SMALLINT = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_INTEGER  = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_BIGINT   = 2'd2;
   localparam logic [TYPE_W-1:0] TYPE_BOOL     = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [NB_W-1:0]    nbytes;
      logic [VALUE_W-1:0] value;
   } rec_type;

endpackage

FILE: rtl/text_field_to_binary_copy_encoder_top.sv
// ----------------------------------------------------------------------------
// text_field_to_binary_copy_encoder_top
// Parses decimal or bool field text and emits the binary copy field, a
// big-endian length word and any big-endian value bytes, or an error byte.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  text_char has_char field_end
//                                            field_type is_null
//   rsp      out        rsp_valid/rsp_stall  out_byte out_last out_error
//
// Input beats are taken one per cycle and held back only while a final beat
// waits in the input register for the previous field record to be taken.
// A field gives 1, 4, 5, 6, 8 or 12 result beats from the output register,
// one per cycle while rsp_stall is low; its record passes rec_ff, then cur_ff.
// One finished field record waits while another drains, so a final beat waits
// only when two earlier fields still have bytes to send.
// Reset is synchronous and clears the parser and all queued output.
// ----------------------------------------------------------------------------
module text_field_to_binary_copy_encoder_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tbcenc_pkg::CHAR_W-1:0]  req_text_char,
   input  logic                           req_has_char,
   input  logic                           req_field_end,
   input  logic [tbcenc_pkg::TYPE_W-1:0]  req_field_type,
   input  logic                           req_is_null,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_out_last,
   output logic                           rsp_out_error
);

   logic                 rec_valid;
   logic                 rec_take;
   tbcenc_pkg::rec_type  rec;

   tbcenc_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_char  (req_text_char),
      .req_has_char   (req_has_char),
      .req_field_end  (req_field_end),
      .req_field_type (req_field_type),
      .req_is_null    (req_is_null),
      .rec_valid      (rec_valid),
      .rec            (rec),
      .rec_take       (rec_take)
   );

   tbcenc_serial u_serial (
      .clock         (clock),
      .reset         (reset),
      .rec_valid     (rec_valid),
      .rec           (rec),
      .rec_take      (rec_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .rsp_out_error (rsp_out_error)
   );

`ifndef NO_ASSERTIONS
   a_error_beat_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_error |-> rsp_out_last && rsp_out_byte == 8'h00)
      else $error("error beat is not a lone zero byte");

   a_record_held: assert property (@(posedge clock) disable iff (reset)
      rec_valid && !rec_take |=> rec_valid && $stable(rec))
      else $error("waiting field record was lost or changed");

   a_take_needs_record: assert property (@(posedge clock) disable iff (reset)
      rec_take |-> rec_valid)
      else $error("serialiser took a record that was not there");
`endif

endmodule

FILE: rtl/tbcenc_parse.sv
// ----------------------------------------------------------------------------
// tbcenc_parse
// Input register and text parser. Accumulates the decimal value of a field
// one character per beat and, on the final beat, leaves one field record.
// ----------------------------------------------------------------------------
module tbcenc_parse (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tbcenc_pkg::CHAR_W-1:0]     req_text_char,
   input  logic                              req_has_char,
   input  logic                              req_field_end,
   input  logic [tbcenc_pkg::TYPE_W-1:0]     req_field_type,
   input  logic                              req_is_null,
   output logic                              rec_valid,
   output tbcenc_pkg::rec_type               rec,
   input  logic                              rec_take
);

   localparam logic [1:0] PHASE_WS     = 2'd0;
   localparam logic [1:0] PHASE_SIGN   = 2'd1;
   localparam logic [1:0] PHASE_DIGITS = 2'd2;

   localparam logic [63:0] TOP_MAG   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_POS   = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] LIMIT_LOW = 64'd922337203685477580;
   localparam logic [63:0] LIMIT_NINE = 64'd922337203685477579;

   logic                               in_valid_ff, in_valid_in;
   logic [tbcenc_pkg::CHAR_W-1:0]      in_char_ff;
   logic                               in_has_ff;
   logic                               in_end_ff;
   logic [tbcenc_pkg::TYPE_W-1:0]      in_type_ff;
   logic                               in_null_ff;

   logic [63:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        ovf_ff, ovf_in;
   logic [1:0]  phase_ff, phase_in;
   logic        bad_ff, bad_in;
   logic        seen_ff, seen_in;
   logic [7:0]  first_ff, first_in;
   logic        ended_ff, ended_in;

   logic                 rec_valid_ff, rec_valid_in;
   tbcenc_pkg::rec_type  rec_ff, rec_in;

   logic        accept;
   logic        advance;
   logic [3:0]  digit;
   logic [63:0] limit;
   logic [63:0] value;
   logic [3:0]  nbytes;

   assign advance   = in_valid_ff && (!in_end_ff || !rec_valid_ff || rec_take);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

   assign digit = 4'(in_char_ff - 8'h30);
   assign limit = (digit == 4'd9) ? LIMIT_NINE : LIMIT_LOW;

   always_comb begin
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      phase_in = phase_ff;
      bad_in   = bad_ff;
      seen_in  = seen_ff;
      first_in = first_ff;
      ended_in = ended_ff;
      if (in_has_ff && !ended_ff) begin
         if (in_char_ff == 8'h00) begin
            ended_in = 1'b1;
         end else begin
            if (!seen_ff) begin
               first_in = in_char_ff;
               seen_in  = 1'b1;
            end
            if (!bad_ff) begin
               if (in_char_ff inside {[8'h30:8'h39]}) begin
                  phase_in = PHASE_DIGITS;
                  if (!ovf_ff) begin
                     if (mag_ff > limit) begin
                        ovf_in = 1'b1;
                     end else begin
                        mag_in = (mag_ff << 3) + (mag_ff << 1) + 64'(digit);
                     end
                  end
               end else if (phase_ff == PHASE_WS &&
                            (in_char_ff == 8'h20 || in_char_ff inside {[8'h09:8'h0d]})) begin
                  phase_in = PHASE_WS;
               end else if (phase_ff == PHASE_WS &&
                            (in_char_ff == 8'h2b || in_char_ff == 8'h2d)) begin
                  neg_in   = (in_char_ff == 8'h2d);
                  phase_in = PHASE_SIGN;
               end else begin
                  bad_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      if (neg_in) begin
         value = ovf_in ? TOP_MAG : (64'd0 - mag_in);
      end else begin
         value = (ovf_in || mag_in[63]) ? MAX_POS : mag_in;
      end
      case (in_type_ff)
         tbcenc_pkg::TYPE_SMALLINT: nbytes = 4'd2;
         tbcenc_pkg::TYPE_INTEGER:  nbytes = 4'd4;
         default:                   nbytes = 4'd8;
      endcase
      rec_in.kind   = tbcenc_pkg::KIND_VALUE;
      rec_in.nbytes = nbytes;
      rec_in.value  = value;
      if (in_null_ff) begin
         rec_in.kind = tbcenc_pkg::KIND_NULL;
      end else if (in_type_ff == tbcenc_pkg::TYPE_BOOL) begin
         rec_in.nbytes = 4'd1;
         rec_in.value  = {63'd0, first_in == 8'h74};
         if (first_in != 8'h74 && first_in != 8'h66) begin
            rec_in.kind = tbcenc_pkg::KIND_ERROR;
         end
      end else if (bad_in || (seen_in && phase_in != PHASE_DIGITS)) begin
         rec_in.kind = tbcenc_pkg::KIND_ERROR;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rec_valid_in = rec_valid_ff;
      if (advance && in_end_ff) begin
         rec_valid_in = 1'b1;
      end else if (rec_take) begin
         rec_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_text_char;
         in_has_ff  <= req_has_char;
         in_end_ff  <= req_field_end;
         in_type_ff <= req_field_type;
         in_null_ff <= req_is_null;
      end
      if (advance && in_end_ff) begin
         rec_ff <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rec_valid_ff <= 1'b0;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         phase_ff     <= PHASE_WS;
         bad_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         first_ff     <= '0;
         ended_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rec_valid_ff <= rec_valid_in;
         if (advance) begin
            if (in_end_ff) begin
               mag_ff   <= '0;
               neg_ff   <= 1'b0;
               ovf_ff   <= 1'b0;
               phase_ff <= PHASE_WS;
               bad_ff   <= 1'b0;
               seen_ff  <= 1'b0;
               first_ff <= '0;
               ended_ff <= 1'b0;
            end else begin
               mag_ff   <= mag_in;
               neg_ff   <= neg_in;
               ovf_ff   <= ovf_in;
               phase_ff <= phase_in;
               bad_ff   <= bad_in;
               seen_ff  <= seen_in;
               first_ff <= first_in;
               ended_ff <= ended_in;
            end
         end
      end
   end

endmodule

FILE: rtl/tbcenc_serial.sv
// ----------------------------------------------------------------------------
// tbcenc_serial
// Byte serialiser behind an output register. Turns a record into the length
// word, any big-endian value bytes or an error byte, one per unstalled cycle.
// ----------------------------------------------------------------------------
module tbcenc_serial (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rec_valid,
   input  tbcenc_pkg::rec_type  rec,
   output logic                 rec_take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_last,
   output logic                 rsp_out_error
);

   logic                 cur_valid_ff, cur_valid_in;
   tbcenc_pkg::rec_type  cur_ff;
   logic [3:0]           idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_last_ff;
   logic                 rsp_error_ff;

   logic        emit;
   logic        last_byte;
   logic [3:0]  total;
   logic [3:0]  k;
   logic [3:0]  sel_w;
   logic [2:0]  sel;
   logic [7:0]  byte_out;

   assign emit     = cur_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign rec_take = rec_valid && (!cur_valid_ff || (emit && last_byte));

   assign k     = idx_ff - 4'd4;
   assign sel_w = cur_ff.nbytes - 4'd1 - k;
   assign sel   = sel_w[2:0];

   always_comb begin
      case (cur_ff.kind)
         tbcenc_pkg::KIND_NULL:  total = 4'd4;
         tbcenc_pkg::KIND_ERROR: total = 4'd1;
         default:                total = 4'd4 + cur_ff.nbytes;
      endcase
      last_byte = (idx_ff == total - 4'd1);
      case (cur_ff.kind)
         tbcenc_pkg::KIND_NULL:  byte_out = 8'hff;
         tbcenc_pkg::KIND_ERROR: byte_out = 8'h00;
         default: begin
            if (idx_ff < 4'd4) begin
               byte_out = (idx_ff == 4'd3) ? {4'd0, cur_ff.nbytes} : 8'h00;
            end else begin
               byte_out = cur_ff.value[8*sel +: 8];
            end
         end
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (rec_take) begin
         cur_valid_in = 1'b1;
         idx_in       = 4'd0;
      end else if (emit) begin
         if (last_byte) begin
            cur_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_take) begin
         cur_ff <= rec;
      end
      if (emit) begin
         rsp_byte_ff  <= byte_out;
         rsp_last_ff  <= last_byte;
         rsp_error_ff <= (cur_ff.kind == tbcenc_pkg::KIND_ERROR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_out_error = rsp_error_ff;

endmodule
